>>> rtl/diff_drive_motor_servo_with_watchdog_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the differential drive motor and servo block
// Shared property wrappers clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef DIFF_DRIVE_MOTOR_SERVO_WITH_WATCHDOG_MACROS_SVH
`define DIFF_DRIVE_MOTOR_SERVO_WITH_WATCHDOG_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define DDM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define DDM_ASSERT_NEXT(label, ante, cons, msg) \
	`DDM_ASSERT(label, (ante) |=> (cons), msg)

`endif

>>> rtl/ddm_pkg.sv
// ---------------------------------------------------------------------------
// Differential drive motor and servo package
// Codes, widths, register layout, state types and servo scaling tables.
// ---------------------------------------------------------------------------
package ddm_pkg;

	localparam int SPEED_W     = 14;
	localparam int ELAPSED_W   = 17;
	localparam int ANGLE_W     = 8;
	localparam int ANGLE_MAX   = 180;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 25;
	localparam int ADDR_W      = 4;

	typedef logic [1:0] cmd_code_t;
	localparam cmd_code_t CMD_VELOCITY = 2'd0;
	localparam cmd_code_t CMD_ANGLE    = 2'd1;
	localparam cmd_code_t CMD_TICK     = 2'd2;

	typedef logic [1:0] dir_t;
	localparam dir_t DIR_STOP = 2'd0;
	localparam dir_t DIR_FWD  = 2'd1;
	localparam dir_t DIR_REV  = 2'd2;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_TIMEOUT    = 2'd0;
	localparam reg_idx_t REG_DEADBAND   = 2'd1;
	localparam reg_idx_t REG_SERVO_LOW  = 2'd2;
	localparam reg_idx_t REG_SERVO_HIGH = 2'd3;

	localparam logic [15:0] TIMEOUT_RST    = 16'd500;
	localparam logic [12:0] DEADBAND_RST   = 13'd40;
	localparam logic [15:0] SERVO_LOW_RST  = 16'd3277;
	localparam logic [15:0] SERVO_HIGH_RST = 16'd6554;
	localparam logic [ANGLE_W-1:0] ANGLE_RST = 8'd90;

	typedef struct packed {
		logic [15:0] wd_timeout;
		logic [12:0] deadband;
		logic [15:0] servo_duty_low;
		logic [15:0] servo_duty_high;
	} cfg_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] left_speed;
		logic signed [SPEED_W-1:0] right_speed;
		logic [ANGLE_W-1:0]        angle_deg;
		logic [ELAPSED_W-1:0]      elapsed_ms;
		logic                      watchdog_armed;
	} ddm_state_t;

	typedef logic [RECIP_W-1:0] recip_tab_t [0:ANGLE_MAX];

	// Scaled reciprocal angle/180 in units of 2^-24, rounded down or up.
	function automatic recip_tab_t make_recip(input logic round_up);
		recip_tab_t t;
		longint unsigned num;
		for (int i = 0; i <= ANGLE_MAX; i++) begin
			num = longint'(i) << RECIP_SHIFT;
			if (round_up) begin
				num = num + longint'(ANGLE_MAX - 1);
			end
			t[i] = RECIP_W'(num / ANGLE_MAX);
		end
		return t;
	endfunction

	localparam recip_tab_t RECIP_FLOOR = make_recip(1'b0);
	localparam recip_tab_t RECIP_CEIL  = make_recip(1'b1);

endpackage

>>> rtl/ddm_if.sv
// ---------------------------------------------------------------------------
// Differential drive request and result channels
// Valid/ready channels carrying one command request or one drive result.
// ---------------------------------------------------------------------------
interface ddm_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] linear_rate;
	logic [15:0] turn_rate;
	logic [15:0] servo_target;

	modport source (output valid, command, linear_rate, turn_rate, servo_target, input ready);
	modport sink (input valid, command, linear_rate, turn_rate, servo_target, output ready);
	modport mon (input valid, ready, command, linear_rate, turn_rate, servo_target);
endinterface

interface ddm_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  left_dir;
	logic [7:0]  left_duty;
	logic [1:0]  right_dir;
	logic [7:0]  right_duty;
	logic [15:0] servo_duty;
	logic        braking;

	modport source (output valid, left_dir, left_duty, right_dir, right_duty, servo_duty,
		braking, input ready);
	modport sink (input valid, left_dir, left_duty, right_dir, right_duty, servo_duty,
		braking, output ready);
	modport mon (input valid, ready, left_dir, left_duty, right_dir, right_duty, servo_duty,
		braking);
endinterface

>>> rtl/ddm_cfg.sv
// ---------------------------------------------------------------------------
// Configuration registers
// APB register file holding timeout, deadband and servo duty end points.
// ---------------------------------------------------------------------------
module ddm_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ddm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output ddm_pkg::cfg_t              cfg
);

	ddm_pkg::cfg_t      cfg_q;
	ddm_pkg::reg_idx_t  idx;
	logic               wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wd_timeout      <= ddm_pkg::TIMEOUT_RST;
			cfg_q.deadband        <= ddm_pkg::DEADBAND_RST;
			cfg_q.servo_duty_low  <= ddm_pkg::SERVO_LOW_RST;
			cfg_q.servo_duty_high <= ddm_pkg::SERVO_HIGH_RST;
		end else if (wr_en) begin
			unique case (idx)
				ddm_pkg::REG_TIMEOUT:    cfg_q.wd_timeout      <= pwdata[15:0];
				ddm_pkg::REG_DEADBAND:   cfg_q.deadband        <= pwdata[12:0];
				ddm_pkg::REG_SERVO_LOW:  cfg_q.servo_duty_low  <= pwdata[15:0];
				ddm_pkg::REG_SERVO_HIGH: cfg_q.servo_duty_high <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ddm_pkg::REG_TIMEOUT:    prdata = {16'd0, cfg_q.wd_timeout};
			ddm_pkg::REG_DEADBAND:   prdata = {19'd0, cfg_q.deadband};
			ddm_pkg::REG_SERVO_LOW:  prdata = {16'd0, cfg_q.servo_duty_low};
			ddm_pkg::REG_SERVO_HIGH: prdata = {16'd0, cfg_q.servo_duty_high};
		endcase
	end

endmodule

>>> rtl/ddm_state.sv
// ---------------------------------------------------------------------------
// Mixer and watchdog state
// Applies one command to the stored speeds, servo angle and watchdog, and
// presents the state that follows it.
// ---------------------------------------------------------------------------
module ddm_state (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [1:0]          command,
	input  logic signed [15:0]  linear_rate,
	input  logic signed [15:0]  turn_rate,
	input  logic signed [15:0]  servo_target,
	input  ddm_pkg::cfg_t       cfg,
	output ddm_pkg::ddm_state_t state_nx,
	output logic                braking
);

	localparam logic signed [16:0] SPEED_HI = 17'sd4096;
	localparam logic signed [16:0] SPEED_LO = -17'sd4096;
	localparam logic [ddm_pkg::ELAPSED_W-1:0] ELAPSED_SAT = '1;

	ddm_pkg::ddm_state_t state_q;
	logic signed [16:0]  left_sum;
	logic signed [16:0]  right_sum;

	function automatic logic signed [ddm_pkg::SPEED_W-1:0] sat_speed(
		input logic signed [16:0] v
	);
		logic signed [ddm_pkg::SPEED_W-1:0] r;
		if (v > SPEED_HI) begin
			r = ddm_pkg::SPEED_W'(SPEED_HI);
		end else if (v < SPEED_LO) begin
			r = ddm_pkg::SPEED_W'(SPEED_LO);
		end else begin
			r = ddm_pkg::SPEED_W'(v);
		end
		return r;
	endfunction

	assign left_sum  = {linear_rate[15], linear_rate} - {turn_rate[15], turn_rate};
	assign right_sum = {linear_rate[15], linear_rate} + {turn_rate[15], turn_rate};

	always_comb begin
		state_nx = state_q;
		braking  = 1'b0;
		unique case (command)
			ddm_pkg::CMD_VELOCITY: begin
				state_nx.left_speed     = sat_speed(left_sum);
				state_nx.right_speed    = sat_speed(right_sum);
				state_nx.watchdog_armed = 1'b1;
				state_nx.elapsed_ms     = '0;
			end
			ddm_pkg::CMD_ANGLE: begin
				if (servo_target[15]) begin
					state_nx.angle_deg = '0;
				end else if (servo_target > 16'sd180) begin
					state_nx.angle_deg = ddm_pkg::ANGLE_W'(ddm_pkg::ANGLE_MAX);
				end else begin
					state_nx.angle_deg = servo_target[ddm_pkg::ANGLE_W-1:0];
				end
			end
			ddm_pkg::CMD_TICK: begin
				if (state_q.elapsed_ms != ELAPSED_SAT) begin
					state_nx.elapsed_ms = state_q.elapsed_ms + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (state_nx.watchdog_armed && (state_nx.elapsed_ms > {1'b0, cfg.wd_timeout})) begin
			braking              = 1'b1;
			state_nx.left_speed  = '0;
			state_nx.right_speed = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.left_speed     <= '0;
			state_q.right_speed    <= '0;
			state_q.angle_deg      <= ddm_pkg::ANGLE_RST;
			state_q.elapsed_ms     <= '0;
			state_q.watchdog_armed <= 1'b0;
		end else if (adv) begin
			state_q <= state_nx;
		end
	end

endmodule

>>> rtl/ddm_bridge.sv
// ---------------------------------------------------------------------------
// H-bridge drive
// Turns a Q2.12 speed into a direction code and an 8-bit enable duty.
// ---------------------------------------------------------------------------
module ddm_bridge (
	input  logic signed [ddm_pkg::SPEED_W-1:0] speed,
	input  logic [12:0]                        deadband,
	output logic [1:0]                         dir,
	output logic [7:0]                         duty
);

	logic signed [14:0] s;
	logic signed [14:0] lim;
	logic [12:0]        mag;
	logic [20:0]        scaled;

	assign s      = {speed[ddm_pkg::SPEED_W-1], speed};
	assign lim    = $signed({2'b00, deadband});
	assign mag    = speed[ddm_pkg::SPEED_W-1] ? 13'(-s) : s[12:0];
	assign scaled = {mag, 8'd0} - {8'd0, mag};

	always_comb begin
		if (s > lim) begin
			dir  = ddm_pkg::DIR_FWD;
			duty = scaled[19:12];
		end else if (s < -lim) begin
			dir  = ddm_pkg::DIR_REV;
			duty = scaled[19:12];
		end else begin
			dir  = ddm_pkg::DIR_STOP;
			duty = 8'd0;
		end
	end

endmodule

>>> rtl/ddm_servo.sv
// ---------------------------------------------------------------------------
// Servo duty scaler
// Interpolates the servo duty word between its end points for an angle of
// 0 to 180 degrees, rounding the offset toward minus infinity.
// ---------------------------------------------------------------------------
module ddm_servo (
	input  ddm_pkg::cfg_t              cfg,
	input  logic [ddm_pkg::ANGLE_W-1:0] angle,
	output logic [15:0]                duty
);

	logic signed [16:0]               diff;
	logic                             neg;
	logic [15:0]                      mag;
	logic [ddm_pkg::RECIP_W-1:0]      recip;
	logic [40:0]                      prod;
	logic [15:0]                      qmag;
	logic                             qround;
	logic [15:0]                      qabs;
	logic [16:0]                      offset;
	logic [16:0]                      sum;

	// The reciprocal error stays below 1/180 of a count, so rounding the
	// table up gives the floor and rounding it down gives the ceiling.
	assign diff   = $signed({1'b0, cfg.servo_duty_high}) - $signed({1'b0, cfg.servo_duty_low});
	assign neg    = diff[16];
	assign mag    = neg ? 16'(-diff) : diff[15:0];
	assign recip  = neg ? ddm_pkg::RECIP_FLOOR[angle] : ddm_pkg::RECIP_CEIL[angle];
	assign prod   = 41'(mag) * 41'(recip);
	assign qmag   = prod[39:24];
	assign qround = neg && (prod[23:0] != 24'd0);
	assign qabs   = qmag + 16'(qround);
	assign offset = neg ? (~{1'b0, qabs} + 17'd1) : {1'b0, qabs};
	assign sum    = {1'b0, cfg.servo_duty_low} + offset;
	assign duty   = sum[15:0];

endmodule

>>> rtl/diff_drive_motor_servo_with_watchdog.sv
// ---------------------------------------------------------------------------
// Differential drive motor mixer with command watchdog and servo driver
// Each request is a velocity command, a servo command or a one millisecond
// tick, and each one returns exactly one result with both bridge drives, the
// servo duty word and the brake flag. A request enters every cycle while the
// input side is not stalled; it is held in an input register, then applied to
// the state and shown in the result register once that register is free or
// being taken. The result register stalls the input side only while it is
// full and not being taken. Registers are written over APB and should
// change only while no request is in flight.
// ---------------------------------------------------------------------------
module diff_drive_motor_servo_with_watchdog (
	input  logic                       clk,
	input  logic                       arst_n,
	ddm_cmd_if.sink                    cmd,
	ddm_res_if.source                  res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ddm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	ddm_pkg::cfg_t       cfg;
	ddm_pkg::ddm_state_t state_nx;
	logic                braking;

	logic                valid_s1;
	logic [1:0]          command_s1;
	logic signed [15:0]  linear_rate_s1;
	logic signed [15:0]  turn_rate_s1;
	logic signed [15:0]  servo_target_s1;

	logic                res_valid_q;
	logic [1:0]          left_dir_q;
	logic [7:0]          left_duty_q;
	logic [1:0]          right_dir_q;
	logic [7:0]          right_duty_q;
	logic [15:0]         servo_duty_q;
	logic                braking_q;

	logic                adv;
	logic [1:0]          left_dir;
	logic [7:0]          left_duty;
	logic [1:0]          right_dir;
	logic [7:0]          right_duty;
	logic [15:0]         servo_duty;

	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || adv;

	ddm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ddm_state u_state (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.command      (command_s1),
		.linear_rate  (linear_rate_s1),
		.turn_rate    (turn_rate_s1),
		.servo_target (servo_target_s1),
		.cfg          (cfg),
		.state_nx     (state_nx),
		.braking      (braking)
	);

	ddm_bridge u_left (
		.speed    (state_nx.left_speed),
		.deadband (cfg.deadband),
		.dir      (left_dir),
		.duty     (left_duty)
	);

	ddm_bridge u_right (
		.speed    (state_nx.right_speed),
		.deadband (cfg.deadband),
		.dir      (right_dir),
		.duty     (right_duty)
	);

	ddm_servo u_servo (
		.cfg   (cfg),
		.angle (state_nx.angle_deg),
		.duty  (servo_duty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			command_s1      <= cmd.command;
			linear_rate_s1  <= cmd.linear_rate;
			turn_rate_s1    <= cmd.turn_rate;
			servo_target_s1 <= cmd.servo_target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_dir_q   <= left_dir;
			left_duty_q  <= left_duty;
			right_dir_q  <= right_dir;
			right_duty_q <= right_duty;
			servo_duty_q <= servo_duty;
			braking_q    <= braking;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.left_dir   = left_dir_q;
	assign res.left_duty  = left_duty_q;
	assign res.right_dir  = right_dir_q;
	assign res.right_duty = right_duty_q;
	assign res.servo_duty = servo_duty_q;
	assign res.braking    = braking_q;

endmodule

>>> rtl/ddm_chk.sv
// ---------------------------------------------------------------------------
// Result channel checker
// Watches the result port for brake, stopped-motor duty and stall behavior.
// ---------------------------------------------------------------------------
`include "diff_drive_motor_servo_with_watchdog_macros.svh"

module ddm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  left_dir,
	input logic [7:0]  left_duty,
	input logic [1:0]  right_dir,
	input logic [7:0]  right_duty,
	input logic [15:0] servo_duty,
	input logic        braking
);

	logic        left_idle;
	logic        right_idle;
	logic        left_ok;
	logic        right_ok;
	logic [36:0] res_word;

	assign left_idle  = (left_dir == ddm_pkg::DIR_STOP) && (left_duty == 8'd0);
	assign right_idle = (right_dir == ddm_pkg::DIR_STOP) && (right_duty == 8'd0);
	assign left_ok    = (left_dir != ddm_pkg::DIR_STOP) || (left_duty == 8'd0);
	assign right_ok   = (right_dir != ddm_pkg::DIR_STOP) || (right_duty == 8'd0);
	assign res_word   = {left_dir, left_duty, right_dir, right_duty, servo_duty, braking};

	`DDM_ASSERT(a_brake_stops, (res_valid && braking) |-> (left_idle && right_idle), "Brake result drives a motor")
	`DDM_ASSERT(a_stop_no_duty, res_valid |-> (left_ok && right_ok), "Stopped motor has nonzero duty")
	`DDM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_word), "Stalled result changed")

endmodule

bind diff_drive_motor_servo_with_watchdog ddm_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.left_dir   (res.left_dir),
	.left_duty  (res.left_duty),
	.right_dir  (res.right_dir),
	.right_duty (res.right_duty),
	.servo_duty (res.servo_duty),
	.braking    (res.braking)
);

>>> tb/sv/diff_drive_motor_servo_with_watchdog_checker.sv
// ---------------------------------------------------------------------------
// Drive result checker for the differential drive motor and servo block
// Watches the request, result and register channels and keeps its own copy
// of the mixer, watchdog and servo state. It predicts each drive result when
// a request is accepted and compares every accepted result, field by field,
// with the oldest prediction.
// ---------------------------------------------------------------------------
module diff_drive_motor_servo_with_watchdog_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	ddm_cmd_if.mon                     cmd,
	ddm_res_if.mon                     res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ddm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	input  logic                       pready,
	output int                         mismatches,
	output int                         outstanding,
	output int                         brakes
);

	typedef struct packed {
		ddm_pkg::dir_t left_dir;
		logic [7:0]    left_duty;
		ddm_pkg::dir_t right_dir;
		logic [7:0]    right_duty;
		logic [15:0]   servo_duty;
		logic          braking;
	} drive_t;

	ddm_pkg::cfg_t                      cfg;
	logic signed [ddm_pkg::SPEED_W-1:0] left_cmd;
	logic signed [ddm_pkg::SPEED_W-1:0] right_cmd;
	logic [ddm_pkg::ANGLE_W-1:0]        angle;
	logic [ddm_pkg::ELAPSED_W-1:0]      elapsed;
	logic                               armed;
	drive_t                             drive_expected [$];
	drive_t                             want;

	task automatic flag_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] exp_val);
		if (got !== exp_val) begin
			flag_mismatch($sformatf("%s is %0d, predicted %0d", name, got, exp_val));
		end
	endtask

	function automatic int sat_unit(input int v);
		if (v > 4096) begin
			return 4096;
		end
		if (v < -4096) begin
			return -4096;
		end
		return v;
	endfunction

	function automatic void bridge(input int speed, output ddm_pkg::dir_t dir,
		output logic [7:0] duty);
		int mag;
		mag = (speed < 0) ? -speed : speed;
		if (speed > int'(cfg.deadband)) begin
			dir = ddm_pkg::DIR_FWD;
			duty = 8'(mag * 255 / 4096);
		end else if (speed < -int'(cfg.deadband)) begin
			dir = ddm_pkg::DIR_REV;
			duty = 8'(mag * 255 / 4096);
		end else begin
			dir = ddm_pkg::DIR_STOP;
			duty = 8'd0;
		end
	endfunction

	function automatic drive_t apply_request(input ddm_pkg::cmd_code_t code,
		input logic [15:0] lin_raw, input logic [15:0] turn_raw,
		input logic [15:0] target_raw);
		drive_t d;
		int lin;
		int turn;
		int target;
		int span;
		int prod;
		int quot;
		d = '0;
		lin = $signed(lin_raw);
		turn = $signed(turn_raw);
		target = $signed(target_raw);
		case (code)
			ddm_pkg::CMD_VELOCITY: begin
				left_cmd = ddm_pkg::SPEED_W'(sat_unit(lin - turn));
				right_cmd = ddm_pkg::SPEED_W'(sat_unit(lin + turn));
				armed = 1'b1;
				elapsed = '0;
			end
			ddm_pkg::CMD_ANGLE: begin
				if (target < 0) begin
					angle = '0;
				end else if (target > ddm_pkg::ANGLE_MAX) begin
					angle = ddm_pkg::ANGLE_W'(ddm_pkg::ANGLE_MAX);
				end else begin
					angle = ddm_pkg::ANGLE_W'(target);
				end
			end
			ddm_pkg::CMD_TICK: begin
				if (elapsed != '1) begin
					elapsed = elapsed + 1'b1;
				end
			end
			default: ;
		endcase
		if (armed && elapsed > cfg.wd_timeout) begin
			d.braking = 1'b1;
			left_cmd = '0;
			right_cmd = '0;
		end else begin
			bridge(int'(left_cmd), d.left_dir, d.left_duty);
			bridge(int'(right_cmd), d.right_dir, d.right_duty);
		end
		span = int'(cfg.servo_duty_high) - int'(cfg.servo_duty_low);
		prod = span * int'(angle);
		quot = (prod >= 0) ? prod / ddm_pkg::ANGLE_MAX :
			-((-prod + ddm_pkg::ANGLE_MAX - 1) / ddm_pkg::ANGLE_MAX);
		d.servo_duty = 16'(int'(cfg.servo_duty_low) + quot);
		return d;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.wd_timeout = ddm_pkg::TIMEOUT_RST;
			cfg.deadband = ddm_pkg::DEADBAND_RST;
			cfg.servo_duty_low = ddm_pkg::SERVO_LOW_RST;
			cfg.servo_duty_high = ddm_pkg::SERVO_HIGH_RST;
			left_cmd = '0;
			right_cmd = '0;
			angle = ddm_pkg::ANGLE_RST;
			elapsed = '0;
			armed = 1'b0;
			drive_expected.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (ddm_pkg::reg_idx_t'(paddr[ddm_pkg::ADDR_W-1:2]))
					ddm_pkg::REG_TIMEOUT:    cfg.wd_timeout = pwdata[15:0];
					ddm_pkg::REG_DEADBAND:   cfg.deadband = pwdata[12:0];
					ddm_pkg::REG_SERVO_LOW:  cfg.servo_duty_low = pwdata[15:0];
					ddm_pkg::REG_SERVO_HIGH: cfg.servo_duty_high = pwdata[15:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				if (drive_expected.size() == 0) begin
					flag_mismatch("result arrived with no request outstanding");
				end else begin
					want = drive_expected.pop_front();
					check_field("left_dir", res.left_dir, want.left_dir);
					check_field("left_duty", res.left_duty, want.left_duty);
					check_field("right_dir", res.right_dir, want.right_dir);
					check_field("right_duty", res.right_duty, want.right_duty);
					check_field("servo_duty", res.servo_duty, want.servo_duty);
					check_field("braking", res.braking, want.braking);
				end
			end
			if (cmd.valid && cmd.ready) begin
				want = apply_request(cmd.command, cmd.linear_rate, cmd.turn_rate,
					cmd.servo_target);
				if (want.braking) begin
					brakes++;
				end
				drive_expected.push_back(want);
			end
			outstanding <= drive_expected.size();
		end
	end

endmodule

>>> tb/sv/diff_drive_motor_servo_with_watchdog_test.sv
// ---------------------------------------------------------------------------
// Testbench for the differential drive motor and servo block
// Drives directed and random velocity, servo, tick and unused requests under
// several register settings and several mixes of sender idling and receiver
// stalls, holds the watchdog brake through a long tick run, and leaves the
// prediction and comparison to the checker beside the block.
// ---------------------------------------------------------------------------
module diff_drive_motor_servo_with_watchdog_test;

	localparam int                 STALL_LIMIT = 2000;
	localparam int                 PHASE_ITEMS = 420;
	localparam ddm_pkg::cmd_code_t CMD_UNUSED  = 2'd3;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [ddm_pkg::ADDR_W-1:0]   paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	int send_idle_pct;
	int recv_stall_pct;
	int cur_timeout;
	int mismatches;
	int outstanding;
	int brakes;
	int idle_cycles;
	int items;
	int burst;
	int sent [4];

	ddm_cmd_if cmd();
	ddm_res_if res();

	diff_drive_motor_servo_with_watchdog uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	diff_drive_motor_servo_with_watchdog_checker drive_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.res         (res),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.brakes      (brakes)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			res.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("No request or result moved for %0d cycles.", STALL_LIMIT);
			$display("FAIL diff_drive_motor_servo_with_watchdog");
			$finish;
		end
	end

	task automatic send(input ddm_pkg::cmd_code_t code, input logic [15:0] lin,
		input logic [15:0] turn, input logic [15:0] target);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.command <= code;
		cmd.linear_rate <= lin;
		cmd.turn_rate <= turn;
		cmd.servo_target <= target;
		do begin
			@(posedge clk);
		end while (!cmd.ready);
		sent[code]++;
	endtask

	task automatic settle();
		cmd.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (outstanding != 0);
	endtask

	task automatic write_reg(input ddm_pkg::reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int timeout, input int deadband, input int duty_low,
		input int duty_high);
		settle();
		write_reg(ddm_pkg::REG_TIMEOUT, 32'(timeout));
		write_reg(ddm_pkg::REG_DEADBAND, 32'(deadband));
		write_reg(ddm_pkg::REG_SERVO_LOW, 32'(duty_low));
		write_reg(ddm_pkg::REG_SERVO_HIGH, 32'(duty_high));
		cur_timeout = timeout;
	endtask

	function automatic logic [15:0] random_rate();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(8192)) - 4096);
			2: return 16'(int'($urandom_range(120)) - 60);
			default: return 16'(int'($urandom_range(4096)) - 2048);
		endcase
	endfunction

	task automatic random_request();
		int pick;
		ddm_pkg::cmd_code_t code;
		logic [15:0] target;
		pick = $urandom_range(99);
		if (pick < 45) begin
			code = ddm_pkg::CMD_TICK;
		end else if (pick < 72) begin
			code = ddm_pkg::CMD_VELOCITY;
		end else if (pick < 94) begin
			code = ddm_pkg::CMD_ANGLE;
		end else begin
			code = CMD_UNUSED;
		end
		case ($urandom_range(3))
			0: target = 16'($urandom);
			1: target = 16'($urandom_range(ddm_pkg::ANGLE_MAX));
			2: target = 16'(int'($urandom_range(20)) - 10);
			default: target = 16'(170 + $urandom_range(20));
		endcase
		send(code, random_rate(), random_rate(), target);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		items = 0;
		while (items < PHASE_ITEMS) begin
			if ($urandom_range(9) == 0) begin
				send(ddm_pkg::CMD_VELOCITY, random_rate(), random_rate(), 16'($urandom));
				burst = $urandom_range(2 * cur_timeout + 3);
				repeat (burst) begin
					send(ddm_pkg::CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
				end
				items += burst + 1;
			end else begin
				random_request();
				items++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cur_timeout = ddm_pkg::TIMEOUT_RST;
		cmd.valid <= 1'b0;
		cmd.command <= ddm_pkg::CMD_TICK;
		cmd.linear_rate <= '0;
		cmd.turn_rate <= '0;
		cmd.servo_target <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(ddm_pkg::REG_TIMEOUT, 32'd3);
		send(ddm_pkg::CMD_VELOCITY, 16'h7fff, 16'h8000, 16'h0000);
		send(ddm_pkg::CMD_VELOCITY, 16'h8000, 16'h7fff, 16'hffff);
		send(ddm_pkg::CMD_VELOCITY, 16'd40, 16'd0, 16'h0000);
		send(ddm_pkg::CMD_VELOCITY, 16'd41, 16'd0, 16'h0000);
		send(ddm_pkg::CMD_VELOCITY, -16'sd40, 16'd0, 16'h0000);
		send(ddm_pkg::CMD_VELOCITY, -16'sd41, 16'd0, 16'h0000);
		send(ddm_pkg::CMD_VELOCITY, 16'd4096, 16'd0, 16'h0000);
		send(ddm_pkg::CMD_VELOCITY, 16'd2048, 16'd2048, 16'h0000);
		send(ddm_pkg::CMD_ANGLE, 16'hffff, 16'h0000, 16'h8000);
		send(ddm_pkg::CMD_ANGLE, 16'h0000, 16'hffff, 16'h7fff);
		send(ddm_pkg::CMD_ANGLE, 16'h0000, 16'h0000, 16'd181);
		send(ddm_pkg::CMD_ANGLE, 16'h0000, 16'h0000, 16'd0);
		send(ddm_pkg::CMD_ANGLE, 16'h0000, 16'h0000, 16'd180);
		send(CMD_UNUSED, 16'h1234, 16'hedcb, 16'h0042);
		repeat (4) send(ddm_pkg::CMD_TICK, 16'hffff, 16'hffff, 16'hffff);
		send(ddm_pkg::CMD_ANGLE, 16'h0000, 16'h0000, 16'd90);
		send(CMD_UNUSED, 16'h0000, 16'h0000, 16'h0000);
		send(ddm_pkg::CMD_VELOCITY, 16'h0000, 16'h0000, 16'h0000);
		send(ddm_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'h0000);
		settle();
		write_reg(ddm_pkg::REG_TIMEOUT, 32'd0);
		send(ddm_pkg::CMD_VELOCITY, 16'd1000, -16'sd500, 16'h0000);
		send(ddm_pkg::CMD_TICK, 16'h0000, 16'h0000, 16'h0000);

		configure(5, 0, 0, 65535);
		run_phase(0, 0);
		configure(0, 4096, 65535, 0);
		run_phase(87, 0);
		configure(12, $urandom_range(300), $urandom_range(65535), $urandom_range(65535));
		run_phase(0, 87);
		configure(30, ddm_pkg::DEADBAND_RST, ddm_pkg::SERVO_LOW_RST, ddm_pkg::SERVO_HIGH_RST);
		run_phase(34, 34);

		// Long tick run: the watchdog fires past the timeout and must keep
		// braking on every later tick until the next velocity request.
		configure(255, ddm_pkg::DEADBAND_RST, ddm_pkg::SERVO_LOW_RST, ddm_pkg::SERVO_HIGH_RST);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send(ddm_pkg::CMD_VELOCITY, 16'd4096, 16'd0, 16'h0000);
		repeat (300) send(ddm_pkg::CMD_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
		send(ddm_pkg::CMD_VELOCITY, -16'sd3000, 16'd500, 16'h0000);

		settle();
		repeat (8) @(posedge clk);
		$display("Requests sent: %0d velocity, %0d servo, %0d tick, %0d unused code.",
			sent[ddm_pkg::CMD_VELOCITY], sent[ddm_pkg::CMD_ANGLE], sent[ddm_pkg::CMD_TICK],
			sent[CMD_UNUSED]);
		$display("Watchdog braked %0d results; %0d mismatches over five register settings.",
			brakes, mismatches);
		if (mismatches == 0) begin
			$display("PASS diff_drive_motor_servo_with_watchdog");
		end else begin
			$display("FAIL diff_drive_motor_servo_with_watchdog");
		end
		$finish;
	end

endmodule
